@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge, switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/uss_pkg.sv @@
// ----------------------------------------------------------------------------
// uss_pkg
// Types, constants and helpers of the UTF-8 stream sanitizer.
// ----------------------------------------------------------------------------
package uss_pkg;

	localparam logic [7:0] ASCII_MAX   = 8'h7F;
	localparam logic [7:0] CONT_LO     = 8'h80;
	localparam logic [7:0] CONT_HI     = 8'hBF;
	localparam logic [7:0] LEAD2_LO    = 8'hC2;
	localparam logic [7:0] LEAD2_HI    = 8'hDF;
	localparam logic [7:0] LEAD3_LO    = 8'hE0;
	localparam logic [7:0] LEAD3_HI    = 8'hEF;
	localparam logic [7:0] LEAD4_LO    = 8'hF0;
	localparam logic [7:0] LEAD4_HI    = 8'hF4;

	// Replacement text: backslash u f f f d.
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_U        = 8'h75;
	localparam logic [7:0] CH_F        = 8'h66;
	localparam logic [7:0] CH_D        = 8'h64;
	localparam int         REPL_LEN    = 6;
	localparam logic [2:0] REPL_LAST   = 3'(REPL_LEN - 1);

	typedef struct packed {
		logic [7:0] in_byte;
		logic       string_end;
	} uss_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_done;
		logic       all_valid;
	} uss_out_t;

	// Output work caused by one input item: rep_n replacement texts, then
	// lit_n literal bytes taken from lit in order.
	typedef struct packed {
		logic [2:0]      rep_n;
		logic [2:0]      lit_n;
		logic [3:0][7:0] lit;
		logic            last;
		logic            valid_all;
	} uss_job_t;

	function automatic logic [7:0] repl_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = CH_BSLASH;
			3'd1:    c = CH_U;
			3'd2:    c = CH_F;
			3'd3:    c = CH_F;
			3'd4:    c = CH_F;
			3'd5:    c = CH_D;
			default: c = CH_D;
		endcase
		return c;
	endfunction

	// Sequence length announced by a lead byte, 0 when it is no valid lead.
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] n;
		if (b >= LEAD2_LO && b <= LEAD2_HI) begin
			n = 3'd2;
		end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
			n = 3'd3;
		end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
			n = 3'd4;
		end else begin
			n = 3'd0;
		end
		return n;
	endfunction

endpackage

@@ hw/rtl/uss_front.sv @@
// ----------------------------------------------------------------------------
// uss_front
// Sequence tracker: holds an open UTF-8 sequence and turns each item into
// the output work that it causes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uss_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  uss_pkg::uss_in_t  item,
	output uss_pkg::uss_job_t job
);
	import uss_pkg::*;

	logic [2:0][7:0] held_q, held_d;
	logic [1:0]      held_cnt_q, held_cnt_d;
	logic [2:0]      need_q, need_d;
	logic            invalid_q, invalid_d;

	logic [7:0] b;
	logic       last;
	logic       is_cont;
	logic [2:0] len;
	logic [2:0] rep_base;
	logic       fresh;

	assign b       = item.in_byte;
	assign last    = item.string_end;
	assign is_cont = (b >= CONT_LO) && (b <= CONT_HI);
	assign len     = lead_len(b);

	always_comb begin
		held_d     = held_q;
		held_cnt_d = held_cnt_q;
		need_d     = need_q;
		job.rep_n  = 3'd0;
		job.lit_n  = 3'd0;
		job.last   = last;
		rep_base   = 3'd0;
		fresh      = 1'b0;
		for (int i = 0; i < 3; i++) begin
			job.lit[i] = (2'(i) == held_cnt_q) ? b : held_q[i];
		end
		job.lit[3] = b;

		if (held_cnt_q != 2'd0) begin
			if (is_cont) begin
				if (({1'b0, held_cnt_q} + 3'd1) >= need_q) begin
					job.lit_n  = {1'b0, held_cnt_q} + 3'd1;
					held_cnt_d = 2'd0;
					need_d     = 3'd0;
				end else if (last) begin
					job.rep_n  = {1'b0, held_cnt_q} + 3'd1;
					held_cnt_d = 2'd0;
					need_d     = 3'd0;
				end else begin
					held_d[held_cnt_q] = b;
					held_cnt_d         = held_cnt_q + 2'd1;
				end
			end else begin
				// Broken sequence: replace what is held, then start over on b.
				rep_base   = {1'b0, held_cnt_q};
				held_cnt_d = 2'd0;
				need_d     = 3'd0;
				fresh      = 1'b1;
			end
		end else begin
			fresh = 1'b1;
		end

		if (fresh) begin
			job.rep_n = rep_base;
			if (b <= ASCII_MAX) begin
				job.lit[0] = b;
				job.lit_n  = 3'd1;
			end else if (len == 3'd0 || last) begin
				job.rep_n = rep_base + 3'd1;
			end else begin
				held_d[0]  = b;
				held_cnt_d = 2'd1;
				need_d     = len;
			end
		end

		job.valid_all = !(invalid_q || (job.rep_n != 3'd0));
		invalid_d     = !job.valid_all;
		if (last) begin
			held_cnt_d = 2'd0;
			need_d     = 3'd0;
			invalid_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			held_cnt_q <= 2'd0;
			need_q     <= 3'd0;
			invalid_q  <= 1'b0;
		end else if (take) begin
			held_q     <= held_d;
			held_cnt_q <= held_cnt_d;
			need_q     <= need_d;
			invalid_q  <= invalid_d;
		end
	end

	// An open sequence always still lacks at least one byte.
	`ASSERT_ALWAYS(a_open_seq_short, clk,
		(held_cnt_q != 2'd0) |-> (need_q > {1'b0, held_cnt_q} && need_q <= 3'd4),
		"open sequence length out of range")

endmodule

@@ hw/rtl/uss_emit.sv @@
// ----------------------------------------------------------------------------
// uss_emit
// Output sequencer: walks one job's replacement texts and literal bytes,
// one byte per cycle unless out_ready stalls the output, into the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uss_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_valid,
	input  uss_pkg::uss_job_t  load_job,
	output logic               load_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output uss_pkg::uss_out_t  out_data
);
	import uss_pkg::*;

	uss_job_t   job_s1;
	logic       job_valid_s1;
	logic [2:0] rep_q;
	logic [2:0] chr_q;
	logic [2:0] lit_q;
	uss_out_t   out_q;
	logic       out_valid_q;

	logic       adv;
	logic       in_rep;
	logic       is_end;
	logic       load;
	logic [7:0] cur_byte;

	assign in_rep   = rep_q < job_s1.rep_n;
	assign cur_byte = in_rep ? repl_char(chr_q) : job_s1.lit[lit_q[1:0]];
	assign is_end   = in_rep ?
		((rep_q == job_s1.rep_n - 3'd1) && (chr_q == REPL_LAST) && (job_s1.lit_n == 3'd0)) :
		(lit_q == job_s1.lit_n - 3'd1);
	assign adv        = job_valid_s1 && (!out_valid_q || out_ready);
	assign load_ready = !job_valid_s1 || (adv && is_end);
	// An item that only extends a held sequence produces nothing.
	assign load       = load_valid && load_ready &&
		((load_job.rep_n != 3'd0) || (load_job.lit_n != 3'd0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
			rep_q        <= 3'd0;
			chr_q        <= 3'd0;
			lit_q        <= 3'd0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load) begin
				job_valid_s1 <= 1'b1;
			end else if (adv && is_end) begin
				job_valid_s1 <= 1'b0;
			end
			if (adv) begin
				if (is_end) begin
					rep_q <= 3'd0;
					chr_q <= 3'd0;
					lit_q <= 3'd0;
				end else if (in_rep) begin
					if (chr_q == REPL_LAST) begin
						chr_q <= 3'd0;
						rep_q <= rep_q + 3'd1;
					end else begin
						chr_q <= chr_q + 3'd1;
					end
				end else begin
					lit_q <= lit_q + 3'd1;
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_s1 <= load_job;
		end
		if (adv) begin
			out_q.out_byte    <= cur_byte;
			out_q.run_last    <= is_end;
			out_q.string_done <= is_end && job_s1.last;
			out_q.all_valid   <= is_end && job_s1.last && job_s1.valid_all;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ASSERT_CLK(a_chr_range, clk, arst_n, chr_q <= REPL_LAST,
		"replacement character index out of range")
	`ASSERT_CLK(a_rep_bound, clk, arst_n,
		job_valid_s1 |-> (rep_q <= job_s1.rep_n && lit_q < 3'd4),
		"job counters ran past the job")
	`ASSERT_CLK(a_job_hold, clk, arst_n,
		(job_valid_s1 && !adv) |=> (job_valid_s1 && $stable(job_s1) && $stable(rep_q)
			&& $stable(chr_q) && $stable(lit_q)),
		"stalled job changed")

endmodule

@@ hw/rtl/utf8_stream_sanitizer.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_sanitizer
// Passes a byte string through, replacing each non-ASCII byte outside a whole
// C2..F4 lead + 80..BF continuation sequence by the six characters \ufffd.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid, in_ready  | in_data:  in_byte, string_end
//  out     | out_valid, out_ready| out_data: out_byte, run_last, string_done,
//          |                     |           all_valid
//
// One output byte leaves per cycle unless out_ready stalls it. An item that
// releases bytes holds the input in the sequencer until its last byte is
// sent; plain ASCII flows at one item per cycle without stalls, and a
// replaced byte yields six characters. An item that only extends a held
// sequence is taken with no output. Reset clears the sequence tracker and
// both valid flags; there is no clearing pass. While a job is in the
// sequencer, in_ready falls in the same cycle as out_ready when the output
// register is full; an empty sequencer takes one item whatever out_ready is.
module utf8_stream_sanitizer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  uss_pkg::uss_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output uss_pkg::uss_out_t out_data
);
	import uss_pkg::*;

	uss_job_t job;
	logic     take;

	assign take = in_valid && in_ready;

	uss_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (in_data),
		.job    (job)
	);

	uss_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (in_valid),
		.load_job   (job),
		.load_ready (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
